// ===== sv/mvt_pkg.sv =====
// shared types, constants and register map of the mppt voltage tracker
`default_nettype none

package mvt_pkg;

  localparam int DEF_VOLT_BITS = 16;
  localparam int DEF_CURR_BITS = 16;

  localparam int FIELD_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;

  // tolerance is in 2^-16 A/V, s is in 2^-17 W: scale |s| by 2^13
  localparam int TOL_SHIFT = 13;

  localparam int unsigned CMD_RESET = 25600;

  localparam logic [FIELD_BITS-1:0] RST_VOLTAGE_STEP       = 16'd128;
  localparam logic [FIELD_BITS-1:0] RST_VOLTAGE_MIN        = 16'd12800;
  localparam logic [FIELD_BITS-1:0] RST_VOLTAGE_MAX        = 16'd38400;
  localparam logic [FIELD_BITS-1:0] RST_MPP_TOLERANCE      = 16'd655;
  localparam logic [FIELD_BITS-1:0] RST_MIN_VOLTAGE_CHANGE = 16'd1;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE               = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VOLTAGE_STEP       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VOLTAGE_MIN        = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_VOLTAGE_MAX        = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MPP_TOLERANCE      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_VOLTAGE_CHANGE = 3'd5;

  localparam logic MODE_PO  = 1'b0;
  localparam logic MODE_INC = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [FIELD_BITS-1:0] voltage_step;
    logic [FIELD_BITS-1:0] voltage_min;
    logic [FIELD_BITS-1:0] voltage_max;
    logic [FIELD_BITS-1:0] mpp_tolerance;
    logic [FIELD_BITS-1:0] min_voltage_change;
  } cfg_t;

  // operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MUL_V_I,
    MUL_DI_V,
    MUL_I_DV,
    MUL_ADV_V,
    MUL_TOL_QL,
    MUL_TOL_QH
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    logic     load_pow;
    logic     load_acc;
    logic     add_acc;
    logic     load_q;
    logic     load_rhs;
    logic     add_rhs;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/mvt_cfg.sv =====
// configuration registers of the mppt voltage tracker
`default_nettype none

module mvt_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [mvt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [mvt_pkg::FIELD_BITS-1:0]     cfg_wdata,
  output mvt_pkg::cfg_t                           cfg
);

  mvt_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode               <= mvt_pkg::MODE_PO;
      cfg_r.voltage_step       <= mvt_pkg::RST_VOLTAGE_STEP;
      cfg_r.voltage_min        <= mvt_pkg::RST_VOLTAGE_MIN;
      cfg_r.voltage_max        <= mvt_pkg::RST_VOLTAGE_MAX;
      cfg_r.mpp_tolerance      <= mvt_pkg::RST_MPP_TOLERANCE;
      cfg_r.min_voltage_change <= mvt_pkg::RST_MIN_VOLTAGE_CHANGE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mvt_pkg::REG_MODE:               cfg_r.mode               <= cfg_wdata[0];
        mvt_pkg::REG_VOLTAGE_STEP:       cfg_r.voltage_step       <= cfg_wdata;
        mvt_pkg::REG_VOLTAGE_MIN:        cfg_r.voltage_min        <= cfg_wdata;
        mvt_pkg::REG_VOLTAGE_MAX:        cfg_r.voltage_max        <= cfg_wdata;
        mvt_pkg::REG_MPP_TOLERANCE:      cfg_r.mpp_tolerance      <= cfg_wdata;
        mvt_pkg::REG_MIN_VOLTAGE_CHANGE: cfg_r.min_voltage_change <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== sv/mvt_ctrl.sv =====
// sequencer of the mppt voltage tracker: steps the shared multiplier per sample
`default_nettype none

module mvt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  mvt_pkg::dp_sts_t      sts,
  output mvt_pkg::dp_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MP   = 4'd1;
  localparam logic [3:0] S_MDI  = 4'd2;
  localparam logic [3:0] S_MDV  = 4'd3;
  localparam logic [3:0] S_MQ   = 4'd4;
  localparam logic [3:0] S_MTL  = 4'd5;
  localparam logic [3:0] S_MTH  = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_DEC  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = mvt_pkg::MUL_V_I;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MP;
        end
      end
      S_MP: begin
        cmd.mul_sel = mvt_pkg::MUL_V_I;
        state_nxt   = S_MDI;
      end
      S_MDI: begin
        cmd.load_pow = 1'b1;
        cmd.mul_sel  = mvt_pkg::MUL_DI_V;
        state_nxt    = (sts.mode == mvt_pkg::MODE_INC) ? S_MDV : S_DEC;
      end
      S_MDV: begin
        cmd.load_acc = 1'b1;
        cmd.mul_sel  = mvt_pkg::MUL_I_DV;
        state_nxt    = S_MQ;
      end
      S_MQ: begin
        cmd.add_acc = 1'b1;
        cmd.mul_sel = mvt_pkg::MUL_ADV_V;
        state_nxt   = S_MTL;
      end
      S_MTL: begin
        cmd.load_q  = 1'b1;
        cmd.mul_sel = mvt_pkg::MUL_TOL_QL;
        state_nxt   = S_MTH;
      end
      S_MTH: begin
        cmd.load_rhs = 1'b1;
        cmd.mul_sel  = mvt_pkg::MUL_TOL_QH;
        state_nxt    = S_ACC;
      end
      S_ACC: begin
        cmd.add_rhs = 1'b1;
        state_nxt   = S_DEC;
      end
      S_DEC: begin
        // wait here while the previous word still sits in the output register
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("commit while output register is occupied");

  a_capture_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_MP) && !in_ready)
    else $error("sample capture not followed by power multiply");

  a_po_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MDI) && (sts.mode == mvt_pkg::MODE_PO) |=> (state_r == S_DEC))
    else $error("perturb and observe took the conductance path");

endmodule

`default_nettype wire

// ===== sv/mvt_dp.sv =====
// datapath of the mppt voltage tracker: shared multiplier, state and output register
`default_nettype none

module mvt_dp #(
  parameter int VOLT_BITS = mvt_pkg::DEF_VOLT_BITS,
  parameter int CURR_BITS = mvt_pkg::DEF_CURR_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  mvt_pkg::cfg_t                       cfg,
  input  wire logic [mvt_pkg::FIELD_BITS-1:0] in_current_sample,
  input  mvt_pkg::dp_cmd_t                    cmd,
  output mvt_pkg::dp_sts_t                    sts,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [mvt_pkg::FIELD_BITS-1:0]      out_voltage_command,
  output logic                                out_at_mpp,
  output logic                                out_moving_up
);

  localparam int WIDE_VC = (VOLT_BITS > CURR_BITS) ? VOLT_BITS : CURR_BITS;
  localparam int OPW     = ((WIDE_VC > mvt_pkg::FIELD_BITS) ? WIDE_VC
                                                            : mvt_pkg::FIELD_BITS) + 2;
  localparam int PW      = 2 * OPW;
  localparam int PWRW    = VOLT_BITS + CURR_BITS;
  localparam int SW      = VOLT_BITS + CURR_BITS + 2;
  localparam int QW      = 2 * VOLT_BITS;
  localparam int RW      = 2 * VOLT_BITS + mvt_pkg::FIELD_BITS;
  localparam int LW      = SW + mvt_pkg::TOL_SHIFT;
  localparam int CW      = (LW > RW) ? LW : RW;
  localparam int VW16    = (VOLT_BITS > mvt_pkg::FIELD_BITS) ? VOLT_BITS
                                                             : mvt_pkg::FIELD_BITS;
  localparam int NW      = VW16 + 2;
  localparam logic [VOLT_BITS-1:0] VMASK = '1;

  logic [VOLT_BITS-1:0]   v_r, lastv_r;
  logic [CURR_BITS-1:0]   i_r, lasti_r;
  logic [PWRW-1:0]        pow_r, lastp_r;
  logic                   dir_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [SW-1:0]   acc_r;
  logic [QW-1:0]          q_r;
  logic [RW-1:0]          rhs_r;
  logic [mvt_pkg::FIELD_BITS-1:0] out_cmd_r;
  logic                   out_at_r, out_up_r, out_valid_r;

  logic signed [VOLT_BITS:0] dv;
  logic signed [CURR_BITS:0] di;
  logic [VOLT_BITS-1:0]      adv;
  logic signed [OPW-1:0]     op_a, op_b;
  logic [SW-1:0]             s_mag;
  logic [CW-1:0]             lhs, rhs_ext;
  logic                      mpp_hit, big_dv, pow_gt;
  logic                      s_pos, s_neg, dv_pos, dv_neg;
  logic                      move_up, hold, at;
  logic signed [NW-1:0]      n0, n1, n2, n3, vmin_ext, vmax_ext, vmask_ext;
  logic [VOLT_BITS-1:0]      v_nxt;
  logic                      dir_nxt;

  assign dv  = $signed({1'b0, v_r}) - $signed({1'b0, lastv_r});
  assign di  = $signed({1'b0, i_r}) - $signed({1'b0, lasti_r});
  assign adv = dv[VOLT_BITS] ? VOLT_BITS'(-dv) : VOLT_BITS'(dv);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.mul_sel)
      mvt_pkg::MUL_V_I: begin
        op_a = $signed(OPW'(v_r));
        op_b = $signed(OPW'(i_r));
      end
      mvt_pkg::MUL_DI_V: begin
        op_a = OPW'(di);
        op_b = $signed(OPW'(v_r));
      end
      mvt_pkg::MUL_I_DV: begin
        op_a = $signed(OPW'(i_r));
        op_b = OPW'(dv);
      end
      mvt_pkg::MUL_ADV_V: begin
        op_a = $signed(OPW'(adv));
        op_b = $signed(OPW'(v_r));
      end
      mvt_pkg::MUL_TOL_QL: begin
        // low half of |dV|*V comes straight from the product register
        op_a = $signed(OPW'(cfg.mpp_tolerance));
        op_b = $signed(OPW'(prod_r[VOLT_BITS-1:0]));
      end
      mvt_pkg::MUL_TOL_QH: begin
        op_a = $signed(OPW'(cfg.mpp_tolerance));
        op_b = $signed(OPW'(q_r[QW-1:VOLT_BITS]));
      end
      default: ;
    endcase
  end

  // conductance test: |s| * 2^13 against tol * |dV| * V
  assign s_mag   = acc_r[SW-1] ? SW'($unsigned(-acc_r)) : SW'($unsigned(acc_r));
  assign lhs     = CW'({s_mag, {mvt_pkg::TOL_SHIFT{1'b0}}});
  assign rhs_ext = CW'(rhs_r);
  assign mpp_hit = lhs < rhs_ext;
  assign big_dv  = VW16'(adv) > VW16'(cfg.min_voltage_change);
  assign pow_gt  = pow_r > lastp_r;
  assign s_neg   = acc_r[SW-1];
  assign s_pos   = !acc_r[SW-1] && (acc_r != '0);
  assign dv_neg  = dv[VOLT_BITS];
  assign dv_pos  = !dv[VOLT_BITS] && (dv != '0);

  always_comb begin
    hold    = 1'b0;
    at      = 1'b0;
    move_up = dir_r;
    priority if (cfg.mode == mvt_pkg::MODE_PO) begin
      move_up = pow_gt ? dir_r : !dir_r;
    end else if (!big_dv) begin
      move_up = 1'b1;
    end else if (mpp_hit) begin
      hold = 1'b1;
      at   = 1'b1;
    end else begin
      move_up = (s_pos && dv_pos) || (s_neg && dv_neg);
    end
  end

  // step, then lower clamp, upper clamp and the voltage field width
  assign vmin_ext  = $signed(NW'(cfg.voltage_min));
  assign vmax_ext  = $signed(NW'(cfg.voltage_max));
  assign vmask_ext = $signed(NW'(VMASK));
  assign n0 = move_up ? $signed(NW'(v_r)) + $signed(NW'(cfg.voltage_step))
                      : $signed(NW'(v_r)) - $signed(NW'(cfg.voltage_step));
  assign n1 = (n0 < vmin_ext) ? vmin_ext : n0;
  assign n2 = (n1 > vmax_ext) ? vmax_ext : n1;
  assign n3 = (n2 > vmask_ext) ? vmask_ext : n2;

  assign v_nxt   = hold ? v_r : VOLT_BITS'($unsigned(n3));
  assign dir_nxt = move_up;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (cmd.capture) begin
      i_r <= CURR_BITS'(in_current_sample);
    end
    if (cmd.load_pow) begin
      pow_r <= prod_r[PWRW-1:0];
    end
    if (cmd.load_acc) begin
      acc_r <= SW'(prod_r);
    end else if (cmd.add_acc) begin
      acc_r <= acc_r + SW'(prod_r);
    end
    if (cmd.load_q) begin
      q_r <= prod_r[QW-1:0];
    end
    if (cmd.load_rhs) begin
      rhs_r <= RW'($unsigned(prod_r));
    end else if (cmd.add_rhs) begin
      rhs_r <= rhs_r + (RW'($unsigned(prod_r)) << VOLT_BITS);
    end
    if (cmd.commit) begin
      out_cmd_r <= mvt_pkg::FIELD_BITS'(v_nxt);
      out_at_r  <= at;
      out_up_r  <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= VOLT_BITS'(mvt_pkg::CMD_RESET);
      lastv_r     <= '0;
      lasti_r     <= '0;
      lastp_r     <= '0;
      dir_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        v_r     <= v_nxt;
        dir_r   <= dir_nxt;
        lastv_r <= v_r;
        lasti_r <= i_r;
        lastp_r <= pow_r;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.mode     = cfg.mode;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_voltage_command = out_cmd_r;
  assign out_at_mpp          = out_at_r;
  assign out_moving_up       = out_up_r;

  a_commit_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && (lastv_r == $past(v_r)) && (out_up_r == dir_r))
    else $error("state and output word disagree after commit");

  a_po_no_mpp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (cfg.mode == mvt_pkg::MODE_PO) |=> !out_at_r)
    else $error("mpp flag raised in perturb and observe");

  a_mpp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && at |=> (v_r == $past(v_r)) && (dir_r == $past(dir_r)))
    else $error("command moved at the maximum power point");

endmodule

`default_nettype wire

// ===== sv/mppt_voltage_tracker.sv =====
// top level of the mppt voltage tracker
// Usage:
//   in_valid/in_ready move one current sample word, taken while the source sat
//   at the last voltage command. out_valid/out_ready move one result word:
//   the next clamped voltage command, the at-mpp flag and the search direction.
//   cfg_we/cfg_index/cfg_wdata write one register per cycle; write only while idle.
// Timing:
//   one shared signed multiplier does all products, one per cycle, under the
//   sequencer. Perturb and observe steps through accept, power product, power
//   load and decide for each sample. Incremental conductance steps through accept,
//   v*i, dI*V, I*dV, |dV|*V, two tolerance partial products, sum and decide.
//   The result word is valid the cycle after the decide step.
// Stalls:
//   the output register holds a finished word while the next sample is taken
//   and worked on; the decide step waits only if that word is still not taken.
// Reset:
//   synchronous, active low; registers go to their defaults, command 200 V,
//   previous voltage, current and power zero, direction up, no word pending.
`default_nettype none

module mppt_voltage_tracker #(
  parameter int VOLT_BITS = mvt_pkg::DEF_VOLT_BITS,
  parameter int CURR_BITS = mvt_pkg::DEF_CURR_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mvt_pkg::FIELD_BITS-1:0]   in_current_sample,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mvt_pkg::FIELD_BITS-1:0]        out_voltage_command,
  output logic                                  out_at_mpp,
  output logic                                  out_moving_up,
  input  wire logic                             cfg_we,
  input  wire logic [mvt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [mvt_pkg::FIELD_BITS-1:0]   cfg_wdata
);

  mvt_pkg::cfg_t    cfg;
  mvt_pkg::dp_cmd_t cmd;
  mvt_pkg::dp_sts_t sts;

  mvt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mvt_dp #(
    .VOLT_BITS (VOLT_BITS),
    .CURR_BITS (CURR_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .in_current_sample   (in_current_sample),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_voltage_command (out_voltage_command),
    .out_at_mpp          (out_at_mpp),
    .out_moving_up       (out_moving_up)
  );

endmodule

`default_nettype wire
